// File: rtl/core/tkbt_pkg.sv
// ----------------------------------------------------------------------------
// tkbt_pkg
// Types, codes and widths shared by the timed key block table modules.
// ----------------------------------------------------------------------------
package tkbt_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 264;
    localparam int DUR_W    = 17;
    localparam int NOW_W    = 32;
    localparam int EXP_W    = 33;
    localparam int STATUS_W = 3;

    // Stream payload widths; the tdata widths are rounded up to whole bytes.
    localparam int S_TDATA_W = 320;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 8;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MUTE   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNMUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DURATION = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUERY        = 3'd4;

    // Register index, taken from address bit 2.
    localparam logic REG_MIN_DURATION = 1'b0;
    localparam logic REG_MAX_DURATION = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic rd_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic             valid;
        logic [EXP_W-1:0] expiry;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

// File: rtl/core/timed_key_block_table_core.sv
// ----------------------------------------------------------------------------
// timed_key_block_table_core
// Table of 264-bit keys with expiry times: mute, unmute and query by key.
// ----------------------------------------------------------------------------
// One item is handled at a time and gives exactly one result. After acceptance,
// a scan reads the entry memory one entry per cycle to find both the key and
// the lowest free entry in the same pass, and for mute and unmute also to purge
// expired entries. After the scan, a drain state lets the last read come back,
// and the result is then loaded in the done state. The result load waits as
// long as the previous result is still held in the output register. The next
// item can be accepted in the cycle after the result is loaded. After reset a
// clearing pass marks every entry empty; no item is accepted during it, but
// register writes are.
module timed_key_block_table_core
    import tkbt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata from bit 0: key_w0, key_w1, key_w2, key_w3, key_w4, duration_s,
    // now_s, zero fill.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: op.
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata from bit 0: status, muted, zero fill.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]     prdata,
    output logic                  pready
);

    logic [DUR_W-1:0] r_min_duration;
    logic [DUR_W-1:0] r_max_duration;
    logic             cfg_wr;

    t_cmd                cmd;
    t_stat               stat;
    logic [STATUS_W-1:0] out_status;
    logic                out_muted;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duration <= DUR_W'(300);
            r_max_duration <= DUR_W'(3600);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_DURATION: r_min_duration <= pwdata[DUR_W-1:0];
                REG_MAX_DURATION: r_max_duration <= pwdata[DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_MIN_DURATION: prdata = CFG_DW'(r_min_duration);
            REG_MAX_DURATION: prdata = CFG_DW'(r_max_duration);
            default: prdata = '0;
        endcase
    end

    tkbt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    tkbt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (s_tuser),
        .i_key          (s_tdata[KEY_W-1:0]),
        .i_duration_s   (s_tdata[KEY_W+DUR_W-1:KEY_W]),
        .i_now_s        (s_tdata[KEY_W+DUR_W+NOW_W-1:KEY_W+DUR_W]),
        .i_min_duration (r_min_duration),
        .i_max_duration (r_max_duration),
        .o_out_valid    (m_tvalid),
        .i_out_ready    (m_tready),
        .o_status       (out_status),
        .o_muted        (out_muted)
    );

    assign m_tdata = {{(M_TDATA_W - STATUS_W - 1){1'b0}}, out_muted, out_status};

endmodule

// File: rtl/core/tkbt_ram.sv
// ----------------------------------------------------------------------------
// tkbt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tkbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/tkbt_ctrl.sv
// ----------------------------------------------------------------------------
// tkbt_ctrl
// Sequencer: clearing pass after reset, then accept, scan, drain and finish.
// ----------------------------------------------------------------------------
module tkbt_ctrl
    import tkbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.cnt_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/tkbt_dpath.sv
// ----------------------------------------------------------------------------
// tkbt_dpath
// Entry memory, scan counter, purge and match logic, and the result register.
// ----------------------------------------------------------------------------
module tkbt_dpath
    import tkbt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DUR_W-1:0]    i_duration_s,
    input  logic [NOW_W-1:0]    i_now_s,
    input  logic [DUR_W-1:0]    i_min_duration,
    input  logic [DUR_W-1:0]    i_max_duration,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_muted
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Item held for the duration of its scan.
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [DUR_W-1:0] r_dur;
    logic [NOW_W-1:0] r_now;
    logic             r_purge_op;

    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_match_muted;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_muted;

    logic [$bits(t_entry)-1:0] ram_rd_data;
    t_entry                    rd_entry;
    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    t_entry                    ram_wr_data;

    logic [EXP_W-1:0] now_ext;
    logic             purge_hit;
    logic             live;
    logic             key_eq;

    logic                bad_dur;
    logic                fin_wr;
    logic [IDX_W-1:0]    fin_addr;
    t_entry              fin_entry;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_muted;

    assign rd_entry = ram_rd_data;
    assign now_ext  = {1'b0, r_now};

    // For mute and unmute, an entry that expired before now is dropped during the
    // same pass that looks for the key, so it counts as free and never as a match.
    assign key_eq    = (rd_entry.key == r_key);
    assign purge_hit = r_rd_vld && r_purge_op && rd_entry.valid && (rd_entry.expiry < now_ext);
    assign live      = rd_entry.valid && !purge_hit;

    assign o_stat.cnt_last = (r_cnt == LAST_IDX);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_cnt = '0;
        end else if (i_cmd.clear_wr || i_cmd.rd_en) begin
            n_cnt = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
        end
    end

    always_comb begin
        bad_dur    = (r_dur < i_min_duration) || (r_dur > i_max_duration);
        fin_wr     = 1'b0;
        fin_addr   = r_match_idx;
        fin_entry  = '0;
        fin_status = ST_QUERY;
        fin_muted  = 1'b0;
        case (r_op)
            OP_MUTE: begin
                fin_entry.valid  = 1'b1;
                fin_entry.expiry = now_ext + EXP_W'(r_dur);
                fin_entry.key    = r_key;
                if (bad_dur) begin
                    fin_status = ST_BAD_DURATION;
                end else if (r_match_found) begin
                    fin_wr     = 1'b1;
                    fin_status = ST_STORED;
                end else if (r_free_found) begin
                    fin_wr     = 1'b1;
                    fin_addr   = r_free_idx;
                    fin_status = ST_STORED;
                end else begin
                    fin_status = ST_FULL;
                end
            end
            OP_UNMUTE: begin
                fin_wr     = r_match_found;
                fin_status = ST_REMOVED;
            end
            OP_QUERY: begin
                fin_muted = r_match_found && r_match_muted;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cnt;
        ram_wr_data = '0;
        if (i_cmd.clear_wr) begin
            ram_wr_en = 1'b1;
        end else if (purge_hit) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_rd_idx;
        end else if (i_cmd.finish && fin_wr) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fin_addr;
            ram_wr_data = fin_entry;
        end
    end

    tkbt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_cnt),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_rd_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else if (r_rd_vld) begin
                if (live && key_eq && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
                if (!live && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_key      <= i_key;
            r_dur      <= i_duration_s;
            r_now      <= i_now_s;
            r_purge_op <= (i_op == OP_MUTE) || (i_op == OP_UNMUTE);
        end
        if (r_rd_vld && live && key_eq && !r_match_found) begin
            r_match_idx   <= r_rd_idx;
            r_match_muted <= (rd_entry.expiry > now_ext);
        end
        if (r_rd_vld && !live && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.finish) begin
            r_out_status <= fin_status;
            r_out_muted  <= fin_muted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_muted     = r_out_muted;

`ifndef SYNTHESIS
    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> o_stat.out_free)
        else $error("result loaded while the output register was still occupied");

    a_load_clears_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (!r_match_found && !r_free_found))
        else $error("search flags not cleared for a new item");

    a_match_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_match_found && r_free_found) |-> (r_match_idx != r_free_idx))
        else $error("the same entry was taken both as a match and as free");
`endif

endmodule
